// File: sv/bdqs_pkg.sv
// ----------------------------------------------------------------------------
// bdqs_pkg: shared types and codes for the bounded deque with search
// Operation codes, the per-cell shift command and the search carrier flags.
// ----------------------------------------------------------------------------
`default_nettype none

package bdqs_pkg;

  localparam int DEF_CAPACITY = 16;

  localparam int OP_W = 3;
  localparam int VAL_W = 32;
  localparam int IDX_W = 4;
  localparam int CNT_OUT_W = 5;

  localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
  localparam logic [OP_W-1:0] OP_PREPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
  localparam logic [OP_W-1:0] OP_READ    = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND    = 3'd4;

  // store update command, same for every cell
  typedef struct packed {
    logic append;
    logic prepend;
    logic remove;
  } shift_t;

  // search token walking from the front cell to the back cell
  typedef struct packed {
    logic act;
    logic hit;
  } carrier_t;

endpackage

`default_nettype wire

// File: sv/bdqs_cell.sv
// ----------------------------------------------------------------------------
// bdqs_cell: one storage slot of the deque
// Holds one element, shifts with its neighbors, and checks the search carrier.
// ----------------------------------------------------------------------------
`default_nettype none

module bdqs_cell
  import bdqs_pkg::*;
#(
  parameter int PW = 4,
  parameter int CW = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [PW-1:0]     pos,
  input  wire logic [CW-1:0]     count,
  input  wire shift_t            cmd,
  input  wire logic [VAL_W-1:0]  value,
  input  wire logic [VAL_W-1:0]  left_data,
  input  wire logic [VAL_W-1:0]  right_data,
  input  wire logic [VAL_W-1:0]  key,
  input  wire carrier_t          car_in,
  input  wire logic [PW-1:0]     car_idx_in,
  output logic [VAL_W-1:0]       data,
  output carrier_t               car_out,
  output logic [PW-1:0]          car_idx_out
);

  logic [VAL_W-1:0] data_next;
  logic             occupied;
  logic             front;

  assign occupied = CW'(pos) < count;
  assign front    = pos == '0;

  always_comb begin
    data_next = data;
    if (cmd.prepend) begin
      data_next = front ? value : left_data;
    end else if (cmd.remove) begin
      data_next = right_data;
    end else if (cmd.append && CW'(pos) == count) begin
      data_next = value;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // carrier: first occupied cell that matches marks the hit
  always_ff @(posedge clk) begin
    if (rst) begin
      car_out <= '0;
    end else begin
      car_out.act <= car_in.act;
      car_out.hit <= car_in.hit | (car_in.act & occupied & (data == key));
    end
  end

  always_ff @(posedge clk) begin
    if (car_in.act && !car_in.hit) begin
      car_idx_out <= pos;
    end else begin
      car_idx_out <= car_idx_in;
    end
  end

endmodule

`default_nettype wire

// File: sv/bounded_deque_with_search.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_search: ordered store of signed values with search
// Append, prepend, remove front, read at index and find value over a row of
// cells; one result beat per command beat.
// ----------------------------------------------------------------------------
//
//  channel   | handshake           | payload
//  ----------+---------------------+-------------------------------------------
//  command   | start, busy         | operation, value, index
//  result    | done (one cycle)    | status, read_value, found_index,
//            |                     | element_count
//
// Append, prepend, remove and read: the command beat is taken at an edge and
// its result beat shows in the following cycle; busy stays low so a new
// command may follow at once.
// Find sends a carrier through the row of CAPACITY cells, one cell a cycle;
// busy stays high while it travels, and the result beat shows as busy falls.
// Reset empties the store (count to zero); cell contents are not cleared.
// The receiver cannot stall: done is high for exactly one cycle per result.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_search
  import bdqs_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [OP_W-1:0]       operation,
  input  wire logic signed [VAL_W-1:0] value,
  input  wire logic [IDX_W-1:0]      index,
  output logic                       done,
  output logic                       status,
  output logic signed [VAL_W-1:0]    read_value,
  output logic [IDX_W-1:0]           found_index,
  output logic [CNT_OUT_W-1:0]       element_count
);

  localparam int PW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
  localparam int RD_N = (CAPACITY < 16) ? CAPACITY : 16;

  // stored element count
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // find in progress, carrier launch pulse, held search key
  logic             searching;
  logic             launch;
  logic [VAL_W-1:0] key;

  logic   accept;
  logic   full;
  logic   empty;
  shift_t cmd;

  logic [VAL_W-1:0] cell_data [CAPACITY];
  carrier_t         car      [CAPACITY+1];
  logic [PW-1:0]    car_idx  [CAPACITY+1];

  // combinational result for the non-search commands
  logic             fast_status;
  logic [VAL_W-1:0] fast_rd;
  logic             rd_hit;
  logic [CMPW-1:0]  idx_ext;
  logic [CMPW-1:0]  cnt_ext;
  logic             last_act;

  assign busy   = searching;
  assign accept = start & ~busy;
  assign full   = count == CW'(CAPACITY);
  assign empty  = count == '0;

  always_comb begin
    cmd = '0;
    count_next = count;
    if (accept) begin
      case (operation)
        OP_APPEND: begin
          if (!full) begin
            cmd.append = 1'b1;
            count_next = count + 1'b1;
          end
        end
        OP_PREPEND: begin
          if (!full) begin
            cmd.prepend = 1'b1;
            count_next = count + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (!empty) begin
            cmd.remove = 1'b1;
            count_next = count - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // read at index: only the first sixteen cells are reachable by a 4-bit index
  assign idx_ext = CMPW'(index);
  assign cnt_ext = CMPW'(count);

  always_comb begin
    fast_rd = '0;
    rd_hit  = 1'b0;
    for (int i = 0; i < RD_N; i++) begin
      if (index == IDX_W'(i)) begin
        fast_rd = cell_data[i];
        rd_hit  = 1'b1;
      end
    end
    if (!(idx_ext < cnt_ext)) begin
      rd_hit = 1'b0;
    end
    if (!rd_hit) begin
      fast_rd = '0;
    end
  end

  always_comb begin
    case (operation)
      OP_APPEND:  fast_status = full;
      OP_PREPEND: fast_status = full;
      OP_REMOVE:  fast_status = empty;
      OP_READ:    fast_status = ~rd_hit;
      default:    fast_status = 1'b1;
    endcase
  end

  // row of cells; the carrier enters at the front after the key is loaded
  assign car[0]     = '{act: launch, hit: 1'b0};
  assign car_idx[0] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] left_d;
    logic [VAL_W-1:0] right_d;
    if (g == 0) begin : g_front
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_back
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end

    bdqs_cell #(
      .PW (PW),
      .CW (CW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .pos         (PW'(g)),
      .count       (count),
      .cmd         (cmd),
      .value       (value),
      .left_data   (left_d),
      .right_data  (right_d),
      .key         (key),
      .car_in      (car[g]),
      .car_idx_in  (car_idx[g]),
      .data        (cell_data[g]),
      .car_out     (car[g+1]),
      .car_idx_out (car_idx[g+1])
    );
  end

  assign last_act = car[CAPACITY].act;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      searching <= 1'b0;
      launch    <= 1'b0;
      done      <= 1'b0;
    end else begin
      count  <= count_next;
      launch <= accept && operation == OP_FIND;
      done   <= (accept && operation != OP_FIND) || last_act;
      if (accept && operation == OP_FIND) begin
        searching <= 1'b1;
      end else if (last_act) begin
        searching <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && operation == OP_FIND) begin
      key <= value;
    end
    if (last_act) begin
      status        <= ~car[CAPACITY].hit;
      read_value    <= car[CAPACITY].hit ? key : '0;
      found_index   <= car[CAPACITY].hit ? IDX_W'(car_idx[CAPACITY]) : '0;
      element_count <= CNT_OUT_W'(count);
    end else if (accept && operation != OP_FIND) begin
      status        <= fast_status;
      read_value    <= (operation == OP_READ) ? fast_rd : '0;
      found_index   <= '0;
      element_count <= CNT_OUT_W'(count_next);
    end
  end

endmodule

`default_nettype wire
